// ----- rtl/three_rotor_cipher_assert.svh -----
`ifndef THREE_ROTOR_CIPHER_ASSERT_SVH
`define THREE_ROTOR_CIPHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/trc_pkg.sv -----
`timescale 1ns / 1ps

package trc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int NUM_ROTORS    = 3;

    localparam int LW = $clog2(ALPHABET_SIZE);   // letter index width

    typedef logic [LW-1:0] t_letter;
    typedef logic [1:0]    t_cmd;
    typedef logic [1:0]    t_sel;
    typedef logic [2:0]    t_cfg_idx;

    // request kinds
    localparam t_cmd CMD_LOAD  = 2'd0;
    localparam t_cmd CMD_START = 2'd1;
    localparam t_cmd CMD_CHAR  = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx CFG_START_FIRST  = 3'd0;
    localparam t_cfg_idx CFG_START_SECOND = 3'd1;
    localparam t_cfg_idx CFG_START_THIRD  = 3'd2;
    localparam t_cfg_idx CFG_NOTCH_FIRST  = 3'd3;
    localparam t_cfg_idx CFG_NOTCH_SECOND = 3'd4;

    localparam t_letter LAST_LETTER  = t_letter'(ALPHABET_SIZE - 1);
    localparam t_letter NOTCH_RESET  = t_letter'(ALPHABET_SIZE - 1);
    localparam t_letter NOTCH_NEVER  = '1;        // above the alphabet, never matches

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
    localparam logic [7:0] ASCII_CASE    = 8'h20;

    // one request travelling down the rotor chain
    typedef struct packed {
        t_cmd    kind;
        t_sel    sel;      // rotor being loaded
        t_letter idx;      // contact being loaded
        t_letter val;      // value stored at that contact
        t_letter x;        // letter index in flight
        logic    carry;    // step request for the receiving rotor
    } t_tok;

    // reduce a value below twice the alphabet size
    function automatic t_letter mod_once(input logic [LW:0] v);
        logic [LW:0] d;
        d = v - (LW+1)'(ALPHABET_SIZE);
        return (v >= (LW+1)'(ALPHABET_SIZE)) ? d[LW-1:0] : v[LW-1:0];
    endfunction

endpackage

// ----- rtl/trc_cell.sv -----
`timescale 1ns / 1ps

module trc_cell #(
    parameter int CELL_ID = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  trc_pkg::t_tok     i_tok,
    input  trc_pkg::t_letter  i_start_pos,
    input  trc_pkg::t_letter  i_notch,
    output logic              o_valid,
    input  logic              i_ready,
    output trc_pkg::t_tok     o_tok
);
    import trc_pkg::*;

    logic     r_valid;
    t_tok     r_tok;
    t_tok     n_tok;
    t_letter  r_pos;
    t_letter  n_pos;
    t_letter  r_wire [ALPHABET_SIZE];

    logic     take;
    logic     step;
    t_letter  pos_step;
    t_letter  pos_use;
    t_letter  contact;
    t_letter  mapped;
    t_letter  result;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_tok   = r_tok;

    // odometer step of this rotor
    assign step     = (i_tok.kind == CMD_CHAR) && i_tok.carry;
    assign pos_step = (r_pos == LAST_LETTER) ? '0 : r_pos + t_letter'(1);
    assign pos_use  = step ? pos_step : r_pos;

    // (T[(x + p) mod 26] + 26 - p) mod 26
    assign contact = mod_once({1'b0, i_tok.x} + {1'b0, pos_use});
    assign mapped  = mod_once({1'b0, r_wire[contact]});
    assign result  = mod_once({1'b0, mapped} + ((LW+1)'(ALPHABET_SIZE) - {1'b0, pos_use}));

    always_comb begin
        n_tok       = i_tok;
        n_tok.x     = result;
        n_tok.carry = step && (pos_step == i_notch);
        n_pos       = r_pos;
        unique case (i_tok.kind)
            CMD_START: n_pos = mod_once({1'b0, i_start_pos});
            CMD_CHAR:  n_pos = pos_use;
            default:   n_pos = r_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_tok <= n_tok;
        end
        if (take && (i_tok.kind == CMD_LOAD) && (i_tok.sel == t_sel'(CELL_ID))
                && (i_tok.idx <= LAST_LETTER)) begin
            r_wire[i_tok.idx] <= i_tok.val;
        end
    end

endmodule

// ----- rtl/three_rotor_cipher.sv -----
`timescale 1ns / 1ps

// Three-rotor substitution cipher without reflector. Wiring, start and encipher
// requests enter on the slave stream (kind in tuser) and run down a chain of
// three rotor cells, each with its own 26-entry wiring and position; a cell steps
// on the carry handed from its left neighbor and passes the letter and the next
// carry right. Throughput is one request per cycle unless the master side stalls;
// a letter is registered in each cell in turn. Non-letter bytes and the unused kind
// are taken and dropped at the entry. Loads and starts ride the same chain, so they
// act in request order with the letters around them. Stalls on the master side
// back up through the cells; empty cells still accept. Configuration is to be
// written by the user only while the chain is empty; the block does not enforce it.

`include "three_rotor_cipher_assert.svh"

module three_rotor_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // rotor_select[1:0], wiring_index[6:2],
                                       // wiring_value[11:7], char_in[19:12], zero pad
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    // cipher letter stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // cipher_letter[6:0], zero pad
);
    import trc_pkg::*;

    // configuration registers
    t_letter r_start [NUM_ROTORS];
    t_letter r_notch_first;
    t_letter r_notch_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ROTORS; i++) begin
                r_start[i] <= '0;
            end
            r_notch_first  <= NOTCH_RESET;
            r_notch_second <= NOTCH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_FIRST:  r_start[0]     <= i_cfg_data;
                CFG_START_SECOND: r_start[1]     <= i_cfg_data;
                CFG_START_THIRD:  r_start[2]     <= i_cfg_data;
                CFG_NOTCH_FIRST:  r_notch_first  <= i_cfg_data;
                CFG_NOTCH_SECOND: r_notch_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry decode: fold case, drop non-letters and the unused kind
    t_cmd       in_cmd;
    logic [7:0] in_char;
    logic [7:0] char_up;
    logic [7:0] char_off;
    logic       is_letter;
    logic       keep;
    t_tok       in_tok;

    assign in_cmd  = s_axis_tuser;
    assign in_char = s_axis_tdata[19:12];
    assign char_up = ((in_char >= ASCII_LOWER_A) && (in_char <= ASCII_LOWER_Z))
                   ? in_char - ASCII_CASE : in_char;
    assign is_letter = (char_up >= ASCII_UPPER_A) && (char_up <= ASCII_UPPER_Z);
    assign char_off  = char_up - ASCII_UPPER_A;

    always_comb begin
        keep = 1'b0;
        unique case (in_cmd)
            CMD_LOAD:  keep = 1'b1;
            CMD_START: keep = 1'b1;
            CMD_CHAR:  keep = is_letter;
            default:   keep = 1'b0;
        endcase
    end

    assign in_tok.kind  = in_cmd;
    assign in_tok.sel   = s_axis_tdata[1:0];
    assign in_tok.idx   = s_axis_tdata[6:2];
    assign in_tok.val   = s_axis_tdata[11:7];
    assign in_tok.x     = char_off[LW-1:0];
    assign in_tok.carry = 1'b1;               // first rotor steps on every letter

    // rotor chain
    logic    c_valid [NUM_ROTORS+1];
    logic    c_ready [NUM_ROTORS+1];
    t_tok    c_tok   [NUM_ROTORS+1];
    t_letter c_notch [NUM_ROTORS];

    assign c_valid[0] = s_axis_tvalid && keep;
    assign c_tok[0]   = in_tok;
    // dropped requests are taken whenever the chain head could take one
    assign s_axis_tready = c_ready[0];

    assign c_notch[0] = r_notch_first;
    assign c_notch[1] = r_notch_second;
    assign c_notch[2] = NOTCH_NEVER;          // third rotor carries nowhere

    for (genvar g = 0; g < NUM_ROTORS; g++) begin : g_rotor
        trc_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (c_valid[g]),
            .o_ready     (c_ready[g]),
            .i_tok       (c_tok[g]),
            .i_start_pos (r_start[g]),
            .i_notch     (c_notch[g]),
            .o_valid     (c_valid[g+1]),
            .i_ready     (c_ready[g+1]),
            .o_tok       (c_tok[g+1])
        );
    end

    // last cell register is the output register; only letters leave
    logic       out_is_letter;
    logic [7:0] out_ascii;

    assign out_is_letter = (c_tok[NUM_ROTORS].kind == CMD_CHAR);
    assign c_ready[NUM_ROTORS] = m_axis_tready || !out_is_letter;
    assign out_ascii     = ASCII_UPPER_A + {3'b000, c_tok[NUM_ROTORS].x};

    assign m_axis_tvalid = c_valid[NUM_ROTORS] && out_is_letter;
    assign m_axis_tdata  = {1'b0, out_ascii[6:0]};

    // checks
    `TRC_ASSERT_NOW(a_out_is_upper, m_axis_tvalid,
        (m_axis_tdata >= ASCII_UPPER_A) && (m_axis_tdata <= ASCII_UPPER_Z),
        "cipher letter outside A..Z")

    `TRC_ASSERT_NOW(a_stall_only_on_full, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready && c_valid[1] && c_valid[2],
        "request side stalled while the chain had room")

    `TRC_ASSERT_NEXT(a_letter_reaches_cell, c_valid[0] && c_ready[0],
        c_valid[1],
        "request taken by the first rotor was lost")

endmodule

// ----- verif/three_rotor_cipher_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams and the config port, keeps its own copy of the rotor
// state and compares every cipher letter with the oldest one predicted.
module three_rotor_cipher_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [23:0] i_req_data,   // rotor_select, wiring_index, wiring_value, char_in, pad
    input  logic [1:0]  i_req_kind,   // command
    input  logic        i_ltr_valid,
    input  logic        i_ltr_ready,
    input  logic [7:0]  i_ltr_data,   // cipher_letter, pad
    output int          o_errors,
    output int          o_pending
);
    import trc_pkg::*;

    localparam int ERR_PRINT_MAX = 40;

    typedef struct packed {
        logic [3:0] pad;
        logic [7:0] char_in;
        t_letter    wiring_value;
        t_letter    wiring_index;
        t_sel       rotor_select;
    } t_request_fields;

    t_letter    wiring [NUM_ROTORS*ALPHABET_SIZE];
    t_letter    rotor_pos [NUM_ROTORS];
    t_letter    start_pos [NUM_ROTORS];
    t_letter    notch_first;
    t_letter    notch_second;
    logic [6:0] cipher_due [$];
    int         mismatch_count = 0;

    assign o_errors = mismatch_count;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < ERR_PRINT_MAX)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // one rotor: offset by position, table lookup, take the position back off
    function automatic t_letter rotor_stage(input int rotor, input t_letter x, input t_letter p);
        int contact;
        int mapped;
        contact = (int'(x) + int'(p)) % ALPHABET_SIZE;
        mapped  = int'(wiring[rotor*ALPHABET_SIZE + contact]);
        return t_letter'((mapped + ALPHABET_SIZE - int'(p)) % ALPHABET_SIZE);
    endfunction

    task automatic apply_request(input t_cmd cmd, input t_request_fields f);
        logic [7:0] ch;
        t_letter    x;
        case (cmd)
            CMD_LOAD: begin
                // out-of-range rotor or contact is dropped
                if (f.rotor_select < NUM_ROTORS && f.wiring_index < ALPHABET_SIZE)
                    wiring[int'(f.rotor_select)*ALPHABET_SIZE + int'(f.wiring_index)] =
                        f.wiring_value;
            end
            CMD_START: begin
                for (int r = 0; r < NUM_ROTORS; r++)
                    rotor_pos[r] = t_letter'(int'(start_pos[r]) % ALPHABET_SIZE);
            end
            CMD_CHAR: begin
                ch = f.char_in;
                if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z)
                    ch = ch - ASCII_CASE;
                if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) begin
                    rotor_pos[0] = t_letter'((int'(rotor_pos[0]) + 1) % ALPHABET_SIZE);
                    if (rotor_pos[0] == notch_first) begin
                        rotor_pos[1] = t_letter'((int'(rotor_pos[1]) + 1) % ALPHABET_SIZE);
                        if (rotor_pos[1] == notch_second)
                            rotor_pos[2] = t_letter'((int'(rotor_pos[2]) + 1) % ALPHABET_SIZE);
                    end
                    x = t_letter'(ch - ASCII_UPPER_A);
                    for (int r = 0; r < NUM_ROTORS; r++)
                        x = rotor_stage(r, x, rotor_pos[r]);
                    cipher_due.push_back(7'(ASCII_UPPER_A + 8'(x)));
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        logic [6:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ROTORS*ALPHABET_SIZE; i++)
                wiring[i] = '0;
            for (int r = 0; r < NUM_ROTORS; r++) begin
                rotor_pos[r] = '0;
                start_pos[r] = '0;
            end
            notch_first  = NOTCH_RESET;
            notch_second = NOTCH_RESET;
            cipher_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_START_FIRST:  start_pos[0] = i_cfg_data;
                    CFG_START_SECOND: start_pos[1] = i_cfg_data;
                    CFG_START_THIRD:  start_pos[2] = i_cfg_data;
                    CFG_NOTCH_FIRST:  notch_first  = i_cfg_data;
                    CFG_NOTCH_SECOND: notch_second = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ltr_valid && i_ltr_ready) begin
                if (cipher_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected letter %h", i_ltr_data[6:0]));
                end else begin
                    want = cipher_due.pop_front();
                    if (i_ltr_data[6:0] !== want)
                        report_mismatch($sformatf("cipher_letter got %h want %h",
                                                  i_ltr_data[6:0], want));
                end
            end
            if (i_req_valid && i_req_ready)
                apply_request(t_cmd'(i_req_kind), t_request_fields'(i_req_data));
        end
        o_pending <= cipher_due.size();
    end

endmodule

// ----- verif/tb_three_rotor_cipher.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the three-rotor cipher. The checker beside the
// DUT does all prediction and comparison; this module only drives requests,
// pulls letters and writes configuration while the rotor chain is empty.
module tb_three_rotor_cipher;
    import trc_pkg::*;

    // codes the package leaves unnamed
    localparam t_cmd     CMD_UNUSED   = 2'd3;
    localparam t_cfg_idx CFG_UNUSED   = 3'd7;

    localparam int DRAIN_CYCLES = 10;      // chain is 3 deep, give it slack
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 300;     // long sink stall, fills the chain

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [4:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // rotor_select, wiring_index, wiring_value, char_in, pad
    logic [1:0]  s_axis_tuser;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // cipher_letter, pad

    int errors;
    int pending;
    int cycle_count      = 0;
    int sink_hold_cycles = 0;
    bit src_no_idle      = 1'b0;
    bit sink_no_idle     = 1'b0;

    three_rotor_cipher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    three_rotor_cipher_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_kind  (s_axis_tuser),
        .i_ltr_valid (m_axis_tvalid),
        .i_ltr_ready (m_axis_tready),
        .i_ltr_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Letter sink: random wait before each letter, optional long hold-off.
    // tready is only ever changed once per edge.
    initial begin : letter_sink
        int gap;
        int n;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                n = sink_hold_cycles;
                sink_hold_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            gap = sink_no_idle ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Offer one request and hold it until taken. tvalid stays high on exit so
    // a back-to-back request never drops it in between.
    task automatic send_request(input t_cmd cmd, input t_sel sel, input t_letter idx,
                                input t_letter val, input logic [7:0] ch);
        int gap;
        gap = src_no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0000, ch, val, idx, sel};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // letter request, unused fields carry noise
    task automatic send_letter(input logic [7:0] ch);
        send_request(CMD_CHAR, t_sel'($urandom), t_letter'($urandom), t_letter'($urandom), ch);
    endtask

    // stop offering, wait for every letter, then let the chain run dry
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [4:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [4:0] s1, input logic [4:0] s2, input logic [4:0] s3,
                             input logic [4:0] n1, input logic [4:0] n2);
        settle();
        write_register(CFG_START_FIRST,  s1);
        write_register(CFG_START_SECOND, s2);
        write_register(CFG_START_THIRD,  s3);
        write_register(CFG_NOTCH_FIRST,  n1);
        write_register(CFG_NOTCH_SECOND, n2);
    endtask

    // Fill every contact of every rotor with a fresh permutation, so no
    // letter ever reads an unwritten entry.
    task automatic load_wiring();
        t_letter perm [ALPHABET_SIZE];
        t_letter tmp;
        int      j;
        for (int r = 0; r < NUM_ROTORS; r++) begin
            for (int c = 0; c < ALPHABET_SIZE; c++)
                perm[c] = t_letter'(c);
            for (int c = ALPHABET_SIZE - 1; c > 0; c--) begin
                j = $urandom_range(0, c);
                tmp = perm[c];
                perm[c] = perm[j];
                perm[j] = tmp;
            end
            for (int c = 0; c < ALPHABET_SIZE; c++)
                send_request(CMD_LOAD, t_sel'(r), t_letter'(c), perm[c], 8'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [7:0] boundary_bytes [11];
        logic [7:0] ch;
        t_letter    val;
        int         pick;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_LOAD;

        // letter range edges, their neighbors, the byte extremes and one mid-range lowercase letter
        boundary_bytes = '{ASCII_UPPER_A, ASCII_UPPER_Z, ASCII_LOWER_A, ASCII_LOWER_Z,
                           ASCII_UPPER_A - 8'd1, ASCII_UPPER_Z + 8'd1,
                           ASCII_LOWER_A - 8'd1, ASCII_LOWER_Z + 8'd1,
                           8'h00, 8'hff, ASCII_LOWER_A + 8'd12};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(5'd3, 5'd7, 5'd20, 5'd5, 5'd12);
        load_wiring();

        // --- directed ---
        // loads with a bad rotor or contact must be dropped
        send_request(CMD_LOAD, 2'd3, 5'd5, 5'd31, 8'h00);
        send_request(CMD_LOAD, 2'd0, 5'd26, 5'd0, 8'h00);
        send_request(CMD_LOAD, 2'd2, 5'd31, 5'd31, 8'hff);
        // stored values above the alphabet, reduced at the stage output
        send_request(CMD_LOAD, 2'd1, 5'd0, 5'd31, 8'h00);
        send_request(CMD_LOAD, 2'd2, LAST_LETTER, 5'd26, 8'h00);
        send_request(CMD_START, 2'd0, 5'd0, 5'd0, 8'h00);
        foreach (boundary_bytes[i])
            send_letter(boundary_bytes[i]);
        // unused command, letter byte must not step anything
        send_request(CMD_UNUSED, 2'd3, 5'd31, 5'd31, ASCII_UPPER_A);
        send_request(CMD_START, 2'd3, 5'd31, 5'd31, 8'hff);
        send_letter(ASCII_UPPER_A + 8'd16);

        // --- random phases, one setting each ---
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                // every rotor at the last letter, notches at zero: double carry
                0: configure(5'd25, 5'd25, 5'd25, 5'd0, 5'd0);
                // starts above range reduce, notches above range never fire
                1: begin
                    configure(5'd31, 5'd26, 5'd30, 5'd31, 5'd31);
                    write_register(CFG_UNUSED, 5'($urandom));
                end
                2: configure(5'd0, 5'd0, 5'd0, NOTCH_RESET, NOTCH_RESET);
                5: configure(5'($urandom), 5'($urandom), 5'($urandom),
                             5'($urandom), 5'($urandom));
                default: configure(5'($urandom_range(0, 25)), 5'($urandom_range(0, 25)),
                                   5'($urandom_range(0, 25)), 5'($urandom_range(0, 25)),
                                   5'($urandom_range(0, 25)));
            endcase
            if (ph == 4)
                load_wiring();

            // phase 0 runs flat out on both sides
            src_no_idle  = (ph == 0);
            sink_no_idle = (ph == 0);
            send_request(CMD_START, t_sel'($urandom), t_letter'($urandom),
                         t_letter'($urandom), 8'($urandom));

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // sink holds off while the source keeps pushing: input must stall
                if (ph == 2 && k == 0) begin
                    sink_hold_cycles = HOLD_CYCLES;
                    src_no_idle = 1'b1;
                end
                if (ph == 2 && k == 80)
                    src_no_idle = 1'b0;
                // source pauses mid-message until every letter is out
                if (ph == 3 && k == PHASE_ITEMS / 2)
                    settle();
                if (ph != 0 && k % 64 == 63) begin
                    src_no_idle  = ($urandom_range(0, 3) == 0);
                    sink_no_idle = ($urandom_range(0, 3) == 0);
                end

                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // mostly letters, either case
                    ch = 8'(ASCII_UPPER_A + 8'($urandom_range(0, ALPHABET_SIZE - 1)));
                    if ($urandom_range(0, 1))
                        ch = ch + ASCII_CASE;
                    send_letter(ch);
                end else if (pick < 80) begin
                    send_letter(8'($urandom));
                end else if (pick < 90) begin
                    val = ($urandom_range(0, 9) == 0) ? t_letter'($urandom_range(26, 31))
                                                      : t_letter'($urandom_range(0, 25));
                    send_request(CMD_LOAD, t_sel'($urandom_range(0, 2)),
                                 t_letter'($urandom_range(0, 25)), val, 8'($urandom));
                end else if (pick < 94) begin
                    send_request(CMD_START, t_sel'($urandom), t_letter'($urandom),
                                 t_letter'($urandom), 8'($urandom));
                end else if (pick < 97) begin
                    send_request(CMD_UNUSED, t_sel'($urandom), t_letter'($urandom),
                                 t_letter'($urandom), 8'($urandom));
                end else if ($urandom_range(0, 1)) begin
                    send_request(CMD_LOAD, 2'd3, t_letter'($urandom),
                                 t_letter'($urandom), 8'($urandom));
                end else begin
                    send_request(CMD_LOAD, t_sel'($urandom), t_letter'($urandom_range(26, 31)),
                                 t_letter'($urandom), 8'($urandom));
                end
            end
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hang guard
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/trc_pkg.sv
rtl/trc_cell.sv
rtl/three_rotor_cipher.sv
verif/three_rotor_cipher_checker.sv
verif/tb_three_rotor_cipher.sv
